// ===== hw/rtl/bca_pkg.sv =====
// Shared types and constants of the bootstrap covariance accumulator.
`timescale 1ns / 1ps
`default_nettype none
package bca_pkg;

  localparam int unsigned DefVectorLength = 64;
  localparam logic [15:0] SampleCountReset = 16'd100;

  localparam logic [1:0] KIND_MEAN   = 2'd0;
  localparam logic [1:0] KIND_SAMPLE = 2'd1;
  localparam logic [1:0] KIND_READ   = 2'd2;

  typedef struct packed {
    logic [1:0]         kind;
    logic [5:0]         row_index;
    logic [5:0]         col_index;
    logic signed [31:0] sample_value;
  } in_item_t;

  typedef struct packed {
    logic signed [63:0] cov_value;
    logic               saturated;
  } out_item_t;

  typedef struct packed {
    logic start;
    logic done;
  } div_ctl_t;

endpackage
`default_nettype wire

// ===== hw/rtl/bootstrap_covariance_accumulator.sv =====
// Top level of the covariance accumulator around a supplied mean vector.
//
//   channel   signals                     transfer when
//   input     start_i, in_item_i          start_i high and busy_o low
//   result    res_valid_o, res_item_o     res_valid_o high (one cycle, no stall)
//   config    cfg_we_i, cfg_wdata_i       cfg_we_i high
//
// A mean item leaves the block idle; a sample item passes through S_DEV. The
// sample item that completes a vector then runs VECTOR_LENGTH squared
// read-modify-write updates of the matrix memory, one per cycle, followed
// by the pipeline drain in S_DRAIN; that matrix port sets the rate. A read
// item passes through the matrix read (S_RDWAIT), the one-bit-per-cycle
// divider (S_DIV) and the result register, and the next item is not accepted
// until it is done; the result appears for one cycle. After reset the block
// clears all VECTOR_LENGTH squared entries of the matrix memory, one entry
// a cycle, while busy_o is high; configuration writes are taken at any time.
// The receiver cannot stall results.
`timescale 1ns / 1ps
`default_nettype none
module bootstrap_covariance_accumulator
  import bca_pkg::*;
#(
  parameter int unsigned VECTOR_LENGTH = DefVectorLength
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  output logic             busy_o,
  input  wire in_item_t    in_item_i,
  input  wire logic        cfg_we_i,
  input  wire logic [15:0] cfg_wdata_i,
  output logic             res_valid_o,
  output out_item_t        res_item_o
);

  localparam int unsigned IW  = (VECTOR_LENGTH > 1) ? $clog2(VECTOR_LENGTH) : 1;
  localparam int unsigned MD  = VECTOR_LENGTH * VECTOR_LENGTH;
  localparam int unsigned MAW = (MD > 1) ? $clog2(MD) : 1;

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_DEV, S_ACC, S_DRAIN, S_RDWAIT, S_DIV
  } state_e;

  state_e state_q;
  logic [15:0] cnt_reg_q;
  logic        sat_q;
  logic [MAW-1:0] clr_q;
  logic [IW-1:0]  r_q, c_q;
  logic        b_vld_q, c_vld_q;
  logic        res_valid_q;
  out_item_t   res_q;

  // Payload registers.
  logic [IW-1:0]      row_q;
  logic signed [31:0] val_q;
  logic               rd_inrange_q;
  logic [MAW-1:0]     b_addr_q, c_addr_q;
  logic signed [31:0] devr_q, devc_q;
  logic signed [63:0] prod_q;
  logic signed [31:0] mean_rd_q;
  logic signed [63:0] m_rdata_q;

  // Memories.
  logic signed [31:0] mean_mem [VECTOR_LENGTH];
  logic signed [31:0] dev_mem  [VECTOR_LENGTH];
  logic signed [63:0] mat_mem  [MD];

  logic accept, row_ok, col_ok;
  logic [IW-1:0]  in_row;
  logic [MAW-1:0] rd_addr;

  assign accept = start_i && (state_q == S_IDLE);
  assign row_ok = {3'b000, in_item_i.row_index} < 9'(VECTOR_LENGTH);
  assign col_ok = {3'b000, in_item_i.col_index} < 9'(VECTOR_LENGTH);
  assign in_row = IW'(in_item_i.row_index);
  assign rd_addr = MAW'(32'(in_item_i.row_index) * VECTOR_LENGTH
                        + 32'(in_item_i.col_index));

  // Deviation from the mean, clamped to signed 32 bits.
  logic [32:0]        diff;
  logic signed [31:0] dev_val;
  logic               dev_sat;
  always_comb begin
    diff    = {val_q[31], val_q} - {mean_rd_q[31], mean_rd_q};
    dev_sat = diff[32] != diff[31];
    if (dev_sat) begin
      dev_val = diff[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end else begin
      dev_val = $signed(diff[31:0]);
    end
  end

  // Saturating accumulate in the last pipeline stage. The arithmetic shift
  // of the product rounds toward minus infinity.
  logic [63:0]        term;
  logic [64:0]        sum65;
  logic signed [63:0] acc_sum;
  logic               acc_ovf;
  always_comb begin
    term    = {{24{prod_q[63]}}, prod_q[63:24]};
    sum65   = {m_rdata_q[63], m_rdata_q} + {term[63], term};
    acc_ovf = sum65[64] != sum65[63];
    if (acc_ovf) begin
      acc_sum = sum65[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    end else begin
      acc_sum = $signed(sum65[63:0]);
    end
  end

  // Matrix memory ports: one read and one write per cycle. Accumulation
  // touches each entry once per vector, so accesses never overlap.
  logic           m_re, m_we;
  logic [MAW-1:0] m_raddr, m_waddr;
  logic [63:0]    m_wdata;
  always_comb begin
    m_re    = b_vld_q || (accept && in_item_i.kind == KIND_READ && row_ok && col_ok);
    m_raddr = b_vld_q ? b_addr_q : rd_addr;
    m_we    = c_vld_q || (state_q == S_CLEAR);
    m_waddr = c_vld_q ? c_addr_q : clr_q;
    m_wdata = c_vld_q ? acc_sum : 64'd0;
  end

  always_ff @(posedge clk_i) begin
    if (m_re) begin
      m_rdata_q <= mat_mem[m_raddr];
    end
    if (m_we) begin
      mat_mem[m_waddr] <= m_wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && in_item_i.kind == KIND_MEAN && row_ok) begin
      mean_mem[in_row] <= in_item_i.sample_value;
    end
    if (accept && in_item_i.kind == KIND_SAMPLE && row_ok) begin
      mean_rd_q <= mean_mem[in_row];
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_DEV) begin
      dev_mem[row_q] <= dev_val;
    end
    devr_q <= dev_mem[r_q];
    devc_q <= dev_mem[c_q];
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      row_q        <= in_row;
      val_q        <= in_item_i.sample_value;
      rd_inrange_q <= row_ok && col_ok;
    end
    b_addr_q <= MAW'(32'(r_q) * VECTOR_LENGTH + 32'(c_q));
    c_addr_q <= b_addr_q;
    prod_q   <= 64'(devr_q) * 64'(devc_q);
  end

  // Divider for reads.
  logic               div_start;
  logic signed [63:0] div_quot;
  div_ctl_t           div_ctl;
  assign div_start = (state_q == S_RDWAIT);

  bca_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (rd_inrange_q ? m_rdata_q : 64'sd0),
    .divisor_i  ((cnt_reg_q == 16'd0) ? 16'd1 : cnt_reg_q),
    .quotient_o (div_quot),
    .ctl_o      (div_ctl)
  );

  // Control sequencer with its registered outputs.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      cnt_reg_q   <= SampleCountReset;
      sat_q       <= 1'b0;
      clr_q       <= '0;
      r_q         <= '0;
      c_q         <= '0;
      b_vld_q     <= 1'b0;
      c_vld_q     <= 1'b0;
      res_valid_q <= 1'b0;
      res_q       <= '0;
    end else begin
      if (cfg_we_i) begin
        cnt_reg_q <= cfg_wdata_i;
      end
      b_vld_q     <= (state_q == S_ACC);
      c_vld_q     <= b_vld_q;
      res_valid_q <= 1'b0;
      if (c_vld_q && acc_ovf) begin
        sat_q <= 1'b1;
      end
      unique case (state_q)
        S_CLEAR: begin
          clr_q <= clr_q + MAW'(1);
          if (clr_q == MAW'(MD - 1)) begin
            state_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept && in_item_i.kind == KIND_SAMPLE && row_ok) begin
            state_q <= S_DEV;
          end else if (accept && in_item_i.kind == KIND_READ) begin
            state_q <= S_RDWAIT;
          end
        end
        S_DEV: begin
          if (dev_sat) begin
            sat_q <= 1'b1;
          end
          if (9'(row_q) == 9'(VECTOR_LENGTH - 1)) begin
            r_q     <= '0;
            c_q     <= '0;
            state_q <= S_ACC;
          end else begin
            state_q <= S_IDLE;
          end
        end
        S_ACC: begin
          if (c_q == IW'(VECTOR_LENGTH - 1)) begin
            c_q <= '0;
            r_q <= r_q + IW'(1);
            if (r_q == IW'(VECTOR_LENGTH - 1)) begin
              state_q <= S_DRAIN;
            end
          end else begin
            c_q <= c_q + IW'(1);
          end
        end
        S_DRAIN: begin
          if (!b_vld_q && !c_vld_q) begin
            state_q <= S_IDLE;
          end
        end
        S_RDWAIT: begin
          state_q <= S_DIV;
        end
        S_DIV: begin
          if (div_ctl.done) begin
            res_valid_q     <= 1'b1;
            res_q.cov_value <= div_quot;
            res_q.saturated <= sat_q;
            state_q         <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign busy_o      = (state_q != S_IDLE);
  assign res_valid_o = res_valid_q;
  assign res_item_o  = res_q;

  // A result only follows a finished division.
  a_res_after_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> $past(state_q == S_DIV) && $past(div_ctl.done))
    else $error("result without a finished division");

  // Matrix writes from accumulation happen only while the block is busy.
  a_acc_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    c_vld_q |-> busy_o)
    else $error("matrix update while idle");

  // Each result strobe lasts a single cycle.
  a_res_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |=> !res_valid_o)
    else $error("result strobe held");

endmodule
`default_nettype wire

// ===== hw/rtl/bca_div.sv =====
// Radix-2 restoring divider: signed 64-bit dividend by unsigned 16-bit divisor.
`timescale 1ns / 1ps
`default_nettype none
module bca_div
  import bca_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  input  wire logic signed [63:0] dividend_i,
  input  wire logic [15:0]        divisor_i,
  output logic signed [63:0]      quotient_o,
  output div_ctl_t                ctl_o
);

  logic        run_q, run_d;
  logic        done_q, done_d;
  logic [6:0]  cnt_q, cnt_d;
  logic        neg_q, neg_d;
  logic [15:0] div_q, div_d;
  logic [15:0] rem_q, rem_d;
  logic [63:0] quo_q, quo_d;
  logic [16:0] trial;

  always_comb begin
    run_d  = run_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    neg_d  = neg_q;
    div_d  = div_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    trial  = {rem_q, quo_q[63]};
    if (start_i) begin
      run_d = 1'b1;
      cnt_d = 7'd0;
      neg_d = dividend_i[63];
      div_d = divisor_i;
      rem_d = 16'd0;
      quo_d = dividend_i[63] ? (64'd0 - 64'(dividend_i)) : 64'(dividend_i);
    end else if (run_q) begin
      // One quotient bit per cycle.
      if (trial >= {1'b0, div_q}) begin
        rem_d = 16'(trial - {1'b0, div_q});
        quo_d = {quo_q[62:0], 1'b1};
      end else begin
        rem_d = trial[15:0];
        quo_d = {quo_q[62:0], 1'b0};
      end
      cnt_d = cnt_q + 7'd1;
      if (cnt_q == 7'd63) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= 7'd0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    neg_q <= neg_d;
    div_q <= div_d;
    rem_q <= rem_d;
    quo_q <= quo_d;
  end

  assign quotient_o  = neg_q ? $signed(64'd0 - quo_q) : $signed(quo_q);
  assign ctl_o.start = run_q;
  assign ctl_o.done  = done_q;

endmodule
`default_nettype wire
